### rtl/gbf_pkg.sv
// Package for the 8x8 glyph blitter: item types, register map and
// controller/datapath command and status bundles. No dependencies.
package gbf_pkg;

  localparam int unsigned GlyphSize = 8;
  localparam int unsigned GlyphBits = GlyphSize * GlyphSize;
  localparam int unsigned PosW      = $clog2(GlyphBits);

  // APB register map (byte addresses 4*i)
  localparam int unsigned PaddrW = 4;
  localparam logic [1:0] REG_FRAME_BASE = 2'd0;
  localparam logic [1:0] REG_LINE_PITCH = 2'd1;
  localparam logic [1:0] REG_BPP        = 2'd2;

  localparam logic [5:0] BppReset = 6'd32;

  // byte enable codes per pixel size
  localparam logic [3:0] BE_2BYTE = 4'b0011;
  localparam logic [3:0] BE_3BYTE = 4'b0111;
  localparam logic [3:0] BE_4BYTE = 4'b1111;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] draw_color;
    logic [63:0] glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic [3:0]  byte_enable;
    logic        last_write;
  } out_item_t;

  typedef struct packed {
    logic [31:0] frame_base_address;
    logic [15:0] line_pitch_bytes;
    logic [5:0]  bits_per_pixel;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch the accepted item
    logic prep;   // form the first pixel address
    logic step;   // advance the scan by one bit
    logic emit;   // put a write into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic draw_en;   // base nonzero and supported depth
    logic cur_bit;   // glyph bit at the scan position
    logic pos_last;  // scan position is the final bit
    logic out_stall; // output register full and not taken
  } sts_t;

endpackage

### rtl/gbf_if.sv
// Valid/ready channel interfaces for glyph items and write items.
// Depends on gbf_pkg.
interface gbf_in_if;
  logic               valid;
  logic               ready;
  gbf_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gbf_out_if;
  logic               valid;
  logic               ready;
  gbf_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/gbf_cfg_regs.sv
// APB configuration registers: frame base, line pitch, bits per pixel.
// Depends on gbf_pkg.
module gbf_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbf_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output gbf_pkg::cfg_t               cfg_o
);
  import gbf_pkg::*;

  logic [31:0] base_q;
  logic [15:0] pitch_q;
  logic [5:0]  bpp_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      pitch_q <= '0;
      bpp_q   <= BppReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_BASE: base_q  <= pwdata;
        REG_LINE_PITCH: pitch_q <= pwdata[15:0];
        REG_BPP:        bpp_q   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_BASE: prdata = base_q;
      REG_LINE_PITCH: prdata = {16'b0, pitch_q};
      REG_BPP:        prdata = {26'b0, bpp_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.frame_base_address = base_q;
  assign cfg_o.line_pitch_bytes   = pitch_q;
  assign cfg_o.bits_per_pixel     = bpp_q;

endmodule

### rtl/gbf_ctrl.sv
// Sequencer for one glyph: accept, address setup, 64-bit scan.
// Depends on gbf_pkg.
module gbf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gbf_pkg::sts_t sts_i,
  output gbf_pkg::cmd_t cmd_o
);
  import gbf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state_q, state_d;
  logic       advance;

  assign advance = ~(sts_i.cur_bit & sts_i.out_stall);

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.draw_en) state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.step = advance;
        cmd_o.emit = advance & sts_i.cur_bit;
        if (advance && sts_i.pos_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/gbf_dp.sv
// Datapath: held glyph scan register, address generation, output register.
// Depends on gbf_pkg.
module gbf_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbf_pkg::cfg_t      cfg_i,
  input  gbf_pkg::in_item_t  in_item_i,
  input  gbf_pkg::cmd_t      cmd_i,
  output gbf_pkg::sts_t      sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output gbf_pkg::out_item_t out_item_o
);
  import gbf_pkg::*;

  logic [6:0]  bpp_sum;
  logic [3:0]  bpb;
  logic        depth_ok;
  logic [27:0] ypitch_w;
  logic [14:0] xoff_w;
  logic [63:0] scan_w;
  logic [31:0] line_next;

  logic [63:0]     shreg_q;
  logic [PosW-1:0] pos_q;
  logic [27:0]     ypitch_q;
  logic [14:0]     xoff_q;
  logic [31:0]     line_q;
  logic [31:0]     pix_q;
  logic [31:0]     data_q;
  logic [3:0]      be_q;
  logic            out_valid_q;
  out_item_t       out_q;

  // bytes per pixel, rounded up
  assign bpp_sum  = {1'b0, cfg_i.bits_per_pixel} + 7'd7;
  assign bpb      = bpp_sum[6:3];
  assign depth_ok = (bpb == 4'd2) || (bpb == 4'd3) || (bpb == 4'd4);

  assign ypitch_w = {16'b0, in_item_i.pixel_y} * {12'b0, cfg_i.line_pitch_bytes};
  assign xoff_w   = {3'b0, in_item_i.pixel_x} * {12'b0, bpb[2:0]};

  // reorder glyph into scan order, first pixel at the MSB
  always_comb begin
    for (int r = 0; r < GlyphSize; r++) begin
      for (int c = 0; c < GlyphSize; c++) begin
        scan_w[GlyphBits-1-(r*GlyphSize+c)] = in_item_i.glyph_bits[r*GlyphSize+GlyphSize-1-c];
      end
    end
  end

  assign line_next = line_q + {16'b0, cfg_i.line_pitch_bytes};

  // scan position (control)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.load) begin
      pos_q <= '0;
    end else if (cmd_i.step) begin
      pos_q <= pos_q + 1'b1;
    end
  end

  // held item and address generation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      shreg_q  <= scan_w;
      ypitch_q <= ypitch_w;
      xoff_q   <= xoff_w;
      unique case (bpb)
        4'd4:    begin data_q <= in_item_i.draw_color;                be_q <= BE_4BYTE; end
        4'd3:    begin data_q <= {8'b0, in_item_i.draw_color[23:0]};  be_q <= BE_3BYTE; end
        default: begin data_q <= {16'b0, in_item_i.draw_color[15:0]}; be_q <= BE_2BYTE; end
      endcase
    end
    if (cmd_i.prep) begin
      line_q <= cfg_i.frame_base_address + {4'b0, ypitch_q};
      pix_q  <= cfg_i.frame_base_address + {4'b0, ypitch_q} + {17'b0, xoff_q};
    end
    if (cmd_i.step) begin
      shreg_q <= {shreg_q[62:0], 1'b0};
      if (pos_q[2:0] == 3'd7) begin
        line_q <= line_next;
        pix_q  <= line_next + {17'b0, xoff_q};
      end else begin
        pix_q  <= pix_q + {28'b0, bpb};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.write_address <= pix_q;
      out_q.write_data    <= data_q;
      out_q.byte_enable   <= be_q;
      out_q.last_write    <= ~|shreg_q[62:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign sts_o.draw_en   = (cfg_i.frame_base_address != 32'd0) && depth_ok;
  assign sts_o.cur_bit   = shreg_q[63];
  assign sts_o.pos_last  = &pos_q;
  assign sts_o.out_stall = out_valid_q & ~out_ready_i;

endmodule

### rtl/glyph_blit_to_framebuffer.sv
// Top level of the 8x8 glyph blitter.
// Depends on gbf_pkg, gbf_if, gbf_cfg_regs, gbf_ctrl, gbf_dp.
//
// Usage:
//   in_ch carries one glyph item (position, color, 64-bit bitmap). out_ch
//   carries one framebuffer write per set glyph bit, scanned row by row
//   from the top and left to right, with last_write on the final write.
//   The APB port sets frame base, line pitch and bits per pixel; write it
//   only while the block is idle.
// Sequence:
//   An item is taken in the idle state, the prepare state forms the first
//   address, then the scan walks all 64 bit positions, one per cycle when
//   the receiver keeps up; the scan sits on a set bit while the previous
//   write still waits. A zero base address or an unsupported depth makes
//   the item be taken without leaving the idle state, with no writes.
// Reset and stalls:
//   Reset clears the scan and the output register; registers return to
//   base 0, pitch 0, 32 bits per pixel. A stalled receiver holds the scan
//   at the next set bit; the next item is taken while the last write
//   still waits in the output register.
module glyph_blit_to_framebuffer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  gbf_in_if.sink                     in_ch,
  gbf_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbf_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import gbf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  gbf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gbf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_item_i   (in_ch.payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_item_o  (out_ch.payload)
  );

endmodule

### bench/glyph_blit_to_framebuffer_tb.sv
// Self-checking bench for glyph_blit_to_framebuffer: APB register setup, glyph items in,
// pixel writes out, each compared with an in-bench prediction of the blit.
// Depends on gbf_pkg, gbf_if and the RTL under rtl/.
module glyph_blit_to_framebuffer_tb;
  import gbf_pkg::*;

  localparam logic [1:0] REG_UNUSED  = 2'd3;  // no register at this index
  localparam int         DrainCycles = 80;    // covers a full scan with no writes
  localparam int         HoldCycles  = 400;   // long receiver hold-off

  logic clk_i = 1'b0;
  logic rst_ni;

  // APB side
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  gbf_in_if  in_ch ();
  gbf_out_if out_ch ();

  // bench state
  cfg_t        fb_regs;              // shadow of the block's registers
  out_item_t   pixel_writes_due[$];  // predicted writes, oldest first
  logic        in_gaps;
  logic        out_gaps;
  logic        out_hold;
  int unsigned glyphs_sent;
  int unsigned writes_seen;
  int unsigned bad_writes;
  int unsigned reg_writes;

  glyph_blit_to_framebuffer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock, period 4
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #4000000;
    $display("glyph_blit_to_framebuffer: mismatch");
    $finish;
  end

  // expected writes for one glyph under the current register values
  function automatic void plot_glyph_writes(input in_item_t g);
    int unsigned nbytes;
    logic [31:0] data;
    logic [31:0] line;
    logic [3:0]  be;
    out_item_t   prev;
    bit          have_prev;
    nbytes = (int'(fb_regs.bits_per_pixel) + 7) / 8;
    case (nbytes)
      4: begin
        data = g.draw_color;
        be   = BE_4BYTE;
      end
      3: begin
        data = {8'h00, g.draw_color[23:0]};
        be   = BE_3BYTE;
      end
      2: begin
        data = {16'h0000, g.draw_color[15:0]};
        be   = BE_2BYTE;
      end
      default: begin
        data = '0;
        be   = '0;
      end
    endcase
    // zero base or unsupported depth draws nothing
    if (fb_regs.frame_base_address == '0 || be == '0) return;
    have_prev = 1'b0;
    prev      = '0;
    for (int unsigned row = 0; row < GlyphSize; row++) begin
      line = fb_regs.frame_base_address
           + (32'(g.pixel_y) + row) * 32'(fb_regs.line_pitch_bytes);
      for (int unsigned col = 0; col < GlyphSize; col++) begin
        // bit 7 of each row byte is the leftmost column
        if (g.glyph_bits[8*row + 7 - col]) begin
          if (have_prev) pixel_writes_due.push_back(prev);
          prev.write_address = line + (32'(g.pixel_x) + col) * nbytes;
          prev.write_data    = data;
          prev.byte_enable   = be;
          prev.last_write    = 1'b0;
          have_prev          = 1'b1;
        end
      end
    end
    if (have_prev) begin
      prev.last_write = 1'b1;
      pixel_writes_due.push_back(prev);
    end
  endfunction

  // compare one accepted write with the oldest prediction
  task automatic check_pixel_write(input out_item_t got);
    out_item_t want;
    writes_seen++;
    if (pixel_writes_due.size() == 0) begin
      bad_writes++;
      if (bad_writes <= 10)
        $display("unexpected write: addr %h data %h be %h last %b",
                 got.write_address, got.write_data, got.byte_enable, got.last_write);
    end else begin
      want = pixel_writes_due.pop_front();
      if (got.write_address !== want.write_address || got.write_data !== want.write_data ||
          got.byte_enable !== want.byte_enable || got.last_write !== want.last_write) begin
        bad_writes++;
        if (bad_writes <= 10)
          $display("write %0d: expected addr %h data %h be %h last %b, got %h %h %h %b",
                   writes_seen, want.write_address, want.write_data, want.byte_enable,
                   want.last_write, got.write_address, got.write_data, got.byte_enable,
                   got.last_write);
      end
    end
  endtask

  // write side: random stall bursts, long hold on request
  initial begin : write_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) check_pixel_write(out_ch.payload);
      if (out_hold) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (out_gaps && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // APB write: setup, access, then idle
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_BASE: fb_regs.frame_base_address = value;
      REG_LINE_PITCH: fb_regs.line_pitch_bytes   = value[15:0];
      REG_BPP:        fb_regs.bits_per_pixel     = value[5:0];
      default:        ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [31:0] base, input logic [31:0] pitch,
                          input logic [31:0] bpp);
    reg_write(REG_FRAME_BASE, base);
    reg_write(REG_LINE_PITCH, pitch);
    reg_write(REG_BPP, bpp);
  endtask

  // offer one glyph; valid stays high into the next call unless a gap is drawn
  task automatic send_glyph(input in_item_t g);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= g;
    do @(posedge clk_i); while (!in_ch.ready);
    plot_glyph_writes(g);
    glyphs_sent++;
  endtask

  task automatic send(input int x, input int y, input logic [31:0] color,
                      input logic [63:0] bits);
    in_item_t g;
    g.pixel_x    = 12'(x);
    g.pixel_y    = 12'(y);
    g.draw_color = color;
    g.glyph_bits = bits;
    send_glyph(g);
  endtask

  // stop offering, wait for all predicted writes, then let a dry scan finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pixel_writes_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_glyph();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 64'd1 << $urandom_range(0, 63);
      2:       return '1;
      3, 4:    return a & b & c;
      5, 6:    return a | b;
      default: return a;
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t g;
    g.pixel_x    = 12'($urandom_range(0, 4095));
    g.pixel_y    = 12'($urandom_range(0, 4095));
    g.draw_color = $urandom;
    g.glyph_bits = rand_glyph();
    return g;
  endfunction

  // reset values: base is zero, so nothing is drawn
  task automatic test_reset_state();
    fb_regs.frame_base_address = '0;
    fb_regs.line_pitch_bytes   = '0;
    fb_regs.bits_per_pixel     = BppReset;
    send(5, 9, 32'hCAFE_F00D, '1);
    settle();
  endtask

  // field extremes and the corner bits of the cell
  task automatic test_pixel_extremes();
    set_regs(32'h0010_0000, 32'd2560, 32'd32);
    send(0, 0, 32'hFFFF_FFFF, '1);
    send(4095, 4095, 32'h0000_0000, '1);
    send(17, 3, 32'h1234_5678, 64'h8000_0000_0000_0000);
    send(17, 3, 32'h1234_5678, 64'h0100_0000_0000_0000);
    send(17, 3, 32'h1234_5678, 64'h0000_0000_0000_0080);
    send(17, 3, 32'h1234_5678, 64'h0000_0000_0000_0001);
    send(17, 3, 32'h1234_5678, 64'h0);  // empty glyph
    send(100, 200, 32'h8765_4321, 64'hAA55_AA55_AA55_AA55);
    settle();
  endtask

  // pixel depths: rounding to 2/3/4 bytes, and depths that draw nothing
  task automatic test_pixel_depths();
    int unsigned drawn[5]  = '{16, 24, 9, 17, 25};
    int unsigned skipped[4] = '{8, 0, 63, 40};
    foreach (drawn[i]) begin
      reg_write(REG_BPP, drawn[i]);
      send(33, 7, 32'hA5C3_F00F, 64'h8100_0000_0000_0081);
      settle();
    end
    foreach (skipped[i]) begin
      reg_write(REG_BPP, skipped[i]);
      send(33, 7, 32'hA5C3_F00F, '1);
      settle();
    end
  endtask

  // address arithmetic past 2^32, and a zero pitch
  task automatic test_address_wrap();
    set_regs(32'hFFFF_FFFF, 32'd65535, 32'd24);
    send(4095, 4095, 32'h00C0_FFEE, '1);
    settle();
    set_regs(32'hFFFF_FF00, 32'd0, 32'd32);
    send(4000, 10, 32'h0BAD_BEEF, 64'hF00F_0FF0_3CC3_C33C);
    settle();
  endtask

  // unused index is ignored; upper data bits are dropped
  task automatic test_register_map();
    reg_write(REG_UNUSED, 32'h0);
    send(1, 2, 32'h1111_2222, 64'h0000_0018_1800_0000);
    settle();
    reg_write(REG_LINE_PITCH, 32'hDEAD_0100);
    reg_write(REG_BPP, 32'hFFFF_FFD0);
    send(8, 8, 32'h3333_4444, 64'h0000_0018_1800_0000);
    settle();
    reg_write(REG_FRAME_BASE, 32'h0);
    send(8, 8, 32'h3333_4444, '1);
    settle();
  endtask

  // receiver holds off long while glyphs keep coming, so the input stalls
  task automatic test_backpressure();
    set_regs(32'h0800_0000, 32'd4096, 32'd32);
    fork
      begin
        out_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_hold <= 1'b0;
      end
    join_none
    repeat (6) send(0, 0, $urandom, {$urandom, $urandom} | {$urandom, $urandom});
    settle();
  endtask

  // random glyphs across several register settings; last phase runs without idling
  task automatic test_random_phases();
    logic [31:0] base;
    logic [31:0] pitch;
    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(0, 2))
        0:       base = 32'hFFFF_F000 | $urandom_range(1, 4095);
        1:       base = 32'h0000_0001;
        default: base = $urandom;
      endcase
      if (base == '0) base = 32'h4000_0000;
      case ($urandom_range(0, 3))
        0:       pitch = 32'd65535;
        1:       pitch = 32'd0;
        default: pitch = $urandom_range(0, 65535);
      endcase
      if (phase == 5) begin
        in_gaps  = 1'b0;
        out_gaps <= 1'b0;
      end
      set_regs(base, pitch, $urandom_range(9, 32));
      repeat (25) send_glyph(rand_item());
      settle();
    end
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    out_hold      <= 1'b0;
    out_gaps      <= 1'b1;
    in_gaps       = 1'b1;
    glyphs_sent   = 0;
    writes_seen   = 0;
    bad_writes    = 0;
    reg_writes    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_pixel_extremes();
    test_pixel_depths();
    test_address_wrap();
    test_register_map();
    test_backpressure();
    test_random_phases();

    $display("run covered %0d glyphs, %0d pixel writes and %0d register writes,",
             glyphs_sent, writes_seen, reg_writes);
    $display("with 2/3/4-byte and unsupported depths, zero base and address wrap");
    if (bad_writes == 0 && pixel_writes_due.size() == 0) begin
      $display("glyph_blit_to_framebuffer: match");
    end else begin
      $display("glyph_blit_to_framebuffer: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/gbf_pkg.sv
rtl/gbf_if.sv
rtl/gbf_cfg_regs.sv
rtl/gbf_ctrl.sv
rtl/gbf_dp.sv
rtl/glyph_blit_to_framebuffer.sv
bench/glyph_blit_to_framebuffer_tb.sv
